// File: design/pnce_pkg.sv
package pnce_pkg;

    localparam int AXES_MAX        = 3;
    localparam int DIMS_DEF        = 3;
    localparam int COORD_BITS_DEF  = 8;
    localparam int FIELD_BITS      = 8;
    localparam int N_BITS          = 9;
    localparam int WC_BITS         = 11;
    localparam int INDEX_BITS      = 24;
    localparam int APB_ADDR_BITS   = 3;
    localparam int APB_DATA_BITS   = 32;

    localparam logic [N_BITS-1:0] CELLS_RESET  = 9'd16;
    localparam logic              RADIUS_RESET = 1'b1;

    localparam logic REG_CELLS  = 1'b0;
    localparam logic REG_RADIUS = 1'b1;

    typedef logic [1:0]                   digit_t;
    typedef logic [FIELD_BITS-1:0]        coord_t;
    typedef logic [N_BITS-1:0]            cells_t;
    typedef logic signed [WC_BITS-1:0]    wcoord_t;
    typedef logic [INDEX_BITS-1:0]        index_t;

    typedef struct packed {
        logic valid;
        logic last;
    } ctl_t;

endpackage

// File: design/pnce_seq.sv
module pnce_seq #(
    parameter int DIMS       = 3,
    parameter int COORD_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  pnce_pkg::coord_t                    coord_in [pnce_pkg::AXES_MAX],
    input  logic                                radius,
    input  logic                                en,
    output pnce_pkg::coord_t                    held     [pnce_pkg::AXES_MAX],
    output pnce_pkg::digit_t                    digits   [pnce_pkg::AXES_MAX],
    output pnce_pkg::ctl_t                      issue
);
    import pnce_pkg::*;

    localparam int      MASK_WIDE  = (1 << COORD_BITS) - 1;
    localparam coord_t  COORD_MASK = coord_t'(MASK_WIDE);

    coord_t held_reg   [AXES_MAX];
    coord_t held_next  [AXES_MAX];
    digit_t digits_reg [AXES_MAX];
    digit_t digits_next[AXES_MAX];
    digit_t stepped    [AXES_MAX];
    logic   busy_reg;
    logic   busy_next;
    logic   last_combo;
    logic   accept;
    digit_t top;

    assign top = {radius, 1'b0};

    always_comb begin
        logic carry;
        carry = 1'b1;
        for (int a = 0; a < AXES_MAX; a++) begin
            stepped[a] = digits_reg[a];
            if (a < DIMS && carry) begin
                if (digits_reg[a] < top) begin
                    stepped[a] = digits_reg[a] + 2'd1;
                    carry      = 1'b0;
                end else begin
                    stepped[a] = '0;
                end
            end
        end
        last_combo = carry;
    end

    assign s_tready = !busy_reg || (en && last_combo);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        held_next   = held_reg;
        digits_next = digits_reg;
        busy_next   = busy_reg;
        if (en && busy_reg) begin
            digits_next = stepped;
            if (last_combo) begin
                busy_next = 1'b0;
            end
        end
        if (accept) begin
            for (int a = 0; a < AXES_MAX; a++) begin
                held_next[a]   = (a < DIMS) ? (coord_in[a] & COORD_MASK) : '0;
                digits_next[a] = '0;
            end
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            for (int a = 0; a < AXES_MAX; a++) begin
                digits_reg[a] <= '0;
                held_reg[a]   <= '0;
            end
        end else begin
            busy_reg    <= busy_next;
            digits_reg  <= digits_next;
            held_reg    <= held_next;
        end
    end

    assign held        = held_reg;
    assign digits      = digits_reg;
    assign issue.valid = busy_reg;
    assign issue.last  = last_combo;

endmodule

// File: design/pnce_lane.sv
module pnce_lane (
    input  logic                aclk,
    input  logic                en,
    input  pnce_pkg::coord_t    held,
    input  pnce_pkg::digit_t    digit,
    input  logic                radius,
    input  pnce_pkg::cells_t    cells,
    output pnce_pkg::wcoord_t   wrapped
);
    import pnce_pkg::*;

    wcoord_t sum;
    wcoord_t n_s;
    wcoord_t wrapped_next;
    wcoord_t wrapped_reg;

    assign sum = $signed({3'b000, held}) + $signed({9'd0, digit})
               - $signed({10'd0, radius});
    assign n_s = $signed({2'b00, cells});

    always_comb begin
        if (sum >= n_s) begin
            wrapped_next = sum - n_s;
        end else if (sum[WC_BITS-1]) begin
            wrapped_next = sum + n_s;
        end else begin
            wrapped_next = sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wrapped_reg <= wrapped_next;
        end
    end

    assign wrapped = wrapped_reg;

endmodule

// File: design/pnce_merge.sv
module pnce_merge (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  pnce_pkg::cells_t    cells,
    input  pnce_pkg::wcoord_t   wrapped [pnce_pkg::AXES_MAX],
    input  pnce_pkg::ctl_t      ctl_in,
    output pnce_pkg::index_t    index_out,
    output pnce_pkg::ctl_t      ctl_out
);
    import pnce_pkg::*;

    index_t ext [AXES_MAX];
    index_t n_ext;
    index_t part_reg;
    index_t part_next;
    index_t low_reg;
    index_t index_reg;
    index_t index_next;
    ctl_t   mid_ctl_reg;
    ctl_t   out_ctl_reg;

    always_comb begin
        for (int a = 0; a < AXES_MAX; a++) begin
            ext[a] = index_t'(wrapped[a]);
        end
    end

    assign n_ext      = index_t'(cells);
    assign part_next  = ext[1] + n_ext * ext[2];
    assign index_next = low_reg + n_ext * part_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            part_reg  <= part_next;
            low_reg   <= ext[0];
            index_reg <= index_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_ctl_reg <= '0;
            out_ctl_reg <= '0;
        end else if (en) begin
            mid_ctl_reg <= ctl_in;
            out_ctl_reg <= mid_ctl_reg;
        end
    end

    assign index_out = index_reg;
    assign ctl_out   = out_ctl_reg;

endmodule

// File: design/periodic_neighbor_cell_enumerator_top.sv
// Periodic neighbor-cell enumerator. Each item on the s_ side carries the coordinates of one
// grid cell; the block returns on the m_ side the linear index x + n*(y + n*z) of every cell
// within radius on each axis, wrapping once at the cells_per_axis boundary, axis 0 stepping
// fastest, with tlast on the final index. An item yields (2*radius+1)^DIMS indexes, 27 for
// radius 1 in three dimensions. An offset odometer issues one neighbor per cycle, unless
// m_tready holds the pipeline, to a lane per axis, whose wrapped coordinates a two-multiplier
// merge stage folds into the index. The next item is accepted in the cycle the last neighbor
// of the current one issues. Each index passes the sequencer, lane and merge registers in turn;
// m_tready low holds the whole pipeline. Write cells_per_axis (address 0) and radius
// (address 4) only while no item is in flight.
module periodic_neighbor_cell_enumerator_top #(
    parameter int DIMS       = pnce_pkg::DIMS_DEF,
    parameter int COORD_BITS = pnce_pkg::COORD_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [23:0]                             s_tdata,  // coord_x, coord_y, coord_z
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [23:0]                             m_tdata,  // neighbor_index
    output logic                                    m_tlast,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [pnce_pkg::APB_ADDR_BITS-1:0]      paddr,
    input  logic [pnce_pkg::APB_DATA_BITS-1:0]      pwdata,
    output logic [pnce_pkg::APB_DATA_BITS-1:0]      prdata,
    output logic                                    pready
);
    import pnce_pkg::*;

    cells_t  cells_reg;
    logic    radius_reg;
    logic    wr_en;
    logic    en;
    coord_t  coord_in [AXES_MAX];
    coord_t  held     [AXES_MAX];
    digit_t  digits   [AXES_MAX];
    wcoord_t wrapped  [AXES_MAX];
    ctl_t    issue;
    ctl_t    lane_ctl_reg;
    ctl_t    out_ctl;
    index_t  index_out;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cells_reg  <= CELLS_RESET;
            radius_reg <= RADIUS_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_CELLS:  cells_reg  <= pwdata[N_BITS-1:0];
                REG_RADIUS: radius_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CELLS:  prdata = APB_DATA_BITS'(cells_reg);
            REG_RADIUS: prdata = APB_DATA_BITS'(radius_reg);
            default:    prdata = '0;
        endcase
    end

    assign en = !m_tvalid || m_tready;

    assign coord_in[0] = s_tdata[7:0];
    assign coord_in[1] = s_tdata[15:8];
    assign coord_in[2] = s_tdata[23:16];

    pnce_seq #(
        .DIMS       (DIMS),
        .COORD_BITS (COORD_BITS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .coord_in (coord_in),
        .radius   (radius_reg),
        .en       (en),
        .held     (held),
        .digits   (digits),
        .issue    (issue)
    );

    for (genvar a = 0; a < AXES_MAX; a++) begin : g_lane
        if (a < DIMS) begin : g_used
            pnce_lane u_lane (
                .aclk    (aclk),
                .en      (en),
                .held    (held[a]),
                .digit   (digits[a]),
                .radius  (radius_reg),
                .cells   (cells_reg),
                .wrapped (wrapped[a])
            );
        end else begin : g_unused
            assign wrapped[a] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_ctl_reg <= '0;
        end else if (en) begin
            lane_ctl_reg <= issue;
        end
    end

    pnce_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cells     (cells_reg),
        .wrapped   (wrapped),
        .ctl_in    (lane_ctl_reg),
        .index_out (index_out),
        .ctl_out   (out_ctl)
    );

    assign m_tvalid = out_ctl.valid;
    assign m_tlast  = out_ctl.last;
    assign m_tdata  = index_out;

endmodule

// File: design/pnce_checker.sv
module pnce_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [23:0]                          m_tdata,
    input logic                                 m_tlast,
    input logic                                 psel,
    input logic [pnce_pkg::APB_ADDR_BITS-1:0]   paddr,
    input logic [pnce_pkg::APB_DATA_BITS-1:0]   prdata
);
    import pnce_pkg::*;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_cells_read: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && paddr[2] == REG_CELLS |-> prdata[APB_DATA_BITS-1:N_BITS] == '0)
        else $error("cells_per_axis read has stray bits");

    a_radius_read: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && paddr[2] == REG_RADIUS |-> prdata[APB_DATA_BITS-1:1] == '0)
        else $error("radius read has stray bits");

endmodule

bind periodic_neighbor_cell_enumerator_top pnce_checker u_pnce_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .paddr    (paddr),
    .prdata   (prdata)
);

// File: test/tb_periodic_neighbor_cell_enumerator_top.sv
`timescale 1ns / 1ps

module tb_periodic_neighbor_cell_enumerator_top;
    import pnce_pkg::*;

    class neighbor_tracker;
        cells_t n;
        logic   rad;
        index_t want_index[$];
        logic   want_last[$];
        int     errors;

        function new();
            n      = CELLS_RESET;
            rad    = RADIUS_RESET;
            errors = 0;
        endfunction

        function void set_cells(cells_t value);
            n = value;
        endfunction

        function void set_radius(logic value);
            rad = value;
        endfunction

        // odometer over 0..2*radius per axis, axis 0 fastest
        function void add_cell(logic [23:0] data);
            longint coord[AXES_MAX];
            longint nn, r, t, acc;
            int     span, total, k, a, rest;
            int     digit[AXES_MAX];
            coord[0] = longint'(data[7:0]);
            coord[1] = longint'(data[15:8]);
            coord[2] = longint'(data[23:16]);
            nn       = longint'(n);
            r        = longint'(rad);
            span     = 2 * int'(rad) + 1;
            total    = 1;
            for (a = 0; a < DIMS_DEF; a++) total = total * span;
            for (k = 0; k < total; k++) begin
                rest = k;
                for (a = 0; a < DIMS_DEF; a++) begin
                    digit[a] = rest % span;
                    rest     = rest / span;
                end
                acc = 0;
                for (a = DIMS_DEF - 1; a >= 0; a--) begin
                    t = coord[a] + longint'(digit[a]) - r;
                    if (t >= nn) begin
                        t = t - nn;
                    end else if (t < 0) begin
                        t = t + nn;
                    end
                    acc = acc * nn + t;
                end
                want_index.push_back(acc[INDEX_BITS-1:0]);
                want_last.push_back(k == total - 1);
            end
        endfunction

        function void check_neighbor(index_t got_index, logic got_last);
            index_t ref_index;
            logic   ref_last;
            if (want_index.size() == 0) begin
                $display("%0t: unexpected neighbor_index %0d last %0b", $time, got_index, got_last);
                errors++;
                return;
            end
            ref_index = want_index.pop_front();
            ref_last  = want_last.pop_front();
            if (got_index !== ref_index) begin
                $display("%0t: neighbor_index expected %0d, got %0d", $time, ref_index, got_index);
                errors++;
            end
            if (got_last !== ref_last) begin
                $display("%0t: last expected %0b, got %0b", $time, ref_last, got_last);
                errors++;
            end
        endfunction

        function int pending();
            return want_index.size();
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [23:0]              s_tdata;   // coord_x, coord_y, coord_z
    logic                     m_tvalid;
    logic                     m_tready;
    logic [23:0]              m_tdata;   // neighbor_index
    logic                     m_tlast;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    neighbor_tracker tracker;
    bit              idling;
    bit              squeeze;

    periodic_neighbor_cell_enumerator_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int stall_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic coord_t pick_coord(cells_t n);
        int r;
        int hi;
        r  = $urandom_range(0, 9);
        hi = (n > 256) ? 255 : int'(n) - 1;
        if (hi < 0 || r == 9) return coord_t'($urandom_range(0, 255));
        if (r == 8) return ($urandom_range(0, 1) == 0) ? 8'd0 : coord_t'(hi);
        return coord_t'($urandom_range(0, hi));
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) tracker.add_cell(s_tdata);
        if (aresetn && m_tvalid && m_tready) tracker.check_neighbor(m_tdata, m_tlast);
    end

    initial begin
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (squeeze) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                squeeze = 1'b0;
            end else if (idling && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (stall_len()) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    end

    task automatic send_cell(input coord_t x, input coord_t y, input coord_t z);
        int gap;
        gap = (idling && $urandom_range(0, 1) == 1) ? stall_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input cells_t n, input logic r);
        settle();
        apb_write(REG_CELLS, APB_DATA_BITS'(n));
        tracker.set_cells(n);
        apb_write(REG_RADIUS, APB_DATA_BITS'(r));
        tracker.set_radius(r);
    endtask

    task automatic send_random(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            send_cell(pick_coord(tracker.n), pick_coord(tracker.n), pick_coord(tracker.n));
        end
    endtask

    initial begin
        tracker  = new();
        idling   = 1'b0;
        squeeze  = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idling = 1'b1;
        send_cell(8'd0, 8'd0, 8'd0);
        send_cell(8'd15, 8'd15, 8'd15);
        send_cell(8'd1, 8'd2, 8'd3);
        send_cell(8'd8, 8'd0, 8'd15);
        send_cell(8'd255, 8'd255, 8'd255);
        send_cell(8'd16, 8'd16, 8'd16);
        send_cell(8'hAA, 8'h55, 8'hF0);
        send_cell(8'h55, 8'hAA, 8'h0F);
        send_cell(8'd15, 8'd0, 8'd7);
        send_random(40);

        configure(9'd1, 1'b1);
        idling = 1'b0;
        send_random(40);

        configure(9'd256, 1'b0);
        idling = 1'b1;
        send_cell(8'd0, 8'd0, 8'd0);
        send_cell(8'd255, 8'd255, 8'd255);
        send_cell(8'd128, 8'd1, 8'd254);
        send_random(40);

        configure(9'd256, 1'b1);
        send_cell(8'd255, 8'd0, 8'd255);
        send_random(40);

        configure(9'd2, 1'b1);
        send_random(40);

        configure(9'd3, 1'b0);
        idling = 1'b0;
        send_random(40);

        configure(cells_t'($urandom_range(4, 255)), 1'b1);
        idling  = 1'b1;
        squeeze = 1'b1;
        send_random(45);

        configure(9'd511, 1'b1);
        send_cell(8'd255, 8'd255, 8'd255);
        send_cell(8'd0, 8'd0, 8'd0);
        send_random(30);

        configure(9'd0, 1'b1);
        send_cell(8'd0, 8'd0, 8'd0);
        send_cell(8'd5, 8'd255, 8'd3);
        send_random(30);

        configure(9'd1, 1'b0);
        send_random(30);

        configure(cells_t'($urandom_range(1, 256)), logic'($urandom_range(0, 1)));
        idling = ($urandom_range(0, 3) != 0);
        send_random(75);

        settle();
        if (tracker.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
